>>> rtl/tsp_pkg.sv
// Package for the TLV stream parser: result record type, status codes and
// fixed constants. No dependencies.
`timescale 1ns / 1ps

package tsp_pkg;

  localparam logic [1:0] StatusOk         = 2'd0;
  localparam logic [1:0] StatusMalformed  = 2'd1;
  localparam logic [1:0] StatusEndMissing = 2'd2;
  localparam logic [1:0] StatusTooLong    = 2'd3;

  localparam logic       KindElement = 1'b0;
  localparam logic       KindStatus  = 1'b1;

  localparam logic [15:0] MaxBufferBytes  = 16'hFFFF;
  localparam logic [15:0] HeaderBytes     = 16'd3;
  localparam logic [7:0]  MaxEntriesReset = 8'd16;
  localparam logic [7:0]  EntryCountMax   = 8'hFF;
  localparam logic [7:0]  EndType         = 8'h00;

  // Register index, taken from paddr[2].
  localparam logic        RegMaxEntries = 1'b0;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  element_type;
    logic [15:0] value_length;
    logic [15:0] value_offset;
    logic [1:0]  status;
    logic [15:0] parsed_length;
    logic        last;
  } result_t;

endpackage

>>> rtl/tsp_byte_if.sv
// Byte request channel of the TLV stream parser: valid/ready and one buffer
// byte with its end-of-buffer flag. No dependencies.
`timescale 1ns / 1ps

interface tsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> rtl/tsp_result_if.sv
// Result request channel of the TLV stream parser: valid/ready and one
// element record or final status record. No dependencies.
`timescale 1ns / 1ps

interface tsp_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  element_type;
  logic [15:0] value_length;
  logic [15:0] value_offset;
  logic [1:0]  status;
  logic [15:0] parsed_length;
  logic        last;

  modport source (output valid, output result_kind, output element_type,
                  output value_length, output value_offset, output status,
                  output parsed_length, output last, input ready);
  modport sink (input valid, input result_kind, input element_type,
                input value_length, input value_offset, input status,
                input parsed_length, input last, output ready);
endinterface

>>> rtl/tlv_stream_parser_unit.sv
// TLV stream parser top level: byte-serial parser, result queue and APB
// register. Depends on tsp_pkg, tsp_byte_if and tsp_result_if.
//
// The parser takes one buffer byte per clock cycle and updates its header and
// length counters in the same cycle, so a back-to-back byte stream runs at one
// byte per cycle. Element records and the final status record are written into
// a four-entry result queue that drains one record per cycle while the sink is
// ready; a byte is accepted while the queue has at least two free entries, since
// a last byte that completes an element yields two records. The max_entries
// register lies at byte address 0 and should be written between buffers.
`timescale 1ns / 1ps

module tlv_stream_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  tsp_byte_if.sink    in_i,
  tsp_result_if.source out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tsp_pkg::*;

  localparam logic [2:0] PhType  = 3'd0;
  localparam logic [2:0] PhLenHi = 3'd1;
  localparam logic [2:0] PhLenLo = 3'd2;
  localparam logic [2:0] PhValue = 3'd3;
  localparam logic [2:0] PhDone  = 3'd4;

  logic [7:0]  max_entries_q;
  logic [2:0]  phase_q, phase_d, s_phase;
  logic [15:0] byte_offset_q, byte_offset_d, s_offset;
  logic [15:0] element_start_q, element_start_d, s_start;
  logic [7:0]  held_type_q, held_type_d, s_type;
  logic [15:0] held_length_q, held_length_d, s_length;
  logic [15:0] value_remaining_q, value_remaining_d, s_remaining;
  logic [7:0]  entry_count_q, entry_count_d, s_count;
  logic [1:0]  outcome_q, outcome_d, s_outcome;

  logic        accept;
  logic        elem_valid;
  logic        status_valid;
  logic [15:0] length_full;
  logic [15:0] remaining_next;
  result_t     elem_rec;
  result_t     status_rec;
  result_t     first_rec;

  result_t     fifo_q [4];
  logic [1:0]  wr_ptr_q, rd_ptr_q;
  logic [2:0]  fifo_cnt_q;
  logic        push_first, push_second, pop;
  logic [2:0]  push_cnt;

  // Configuration port
  assign pready = 1'b1;

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == RegMaxEntries) begin
      prdata = {24'd0, max_entries_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= MaxEntriesReset;
    end else if (psel && penable && pwrite && (paddr[2] == RegMaxEntries)) begin
      max_entries_q <= pwdata[7:0];
    end
  end

  // Parser step
  assign accept       = in_i.valid && in_i.ready;
  assign status_valid = accept && in_i.last_byte;
  assign length_full  = {held_length_q[15:8], in_i.data_byte};
  assign remaining_next = (value_remaining_q != 16'd0) ? value_remaining_q - 16'd1
                                                       : 16'd0;

  always_comb begin
    s_phase     = phase_q;
    s_offset    = byte_offset_q;
    s_start     = element_start_q;
    s_type      = held_type_q;
    s_length    = held_length_q;
    s_remaining = value_remaining_q;
    s_count     = entry_count_q;
    s_outcome   = outcome_q;
    elem_valid  = 1'b0;

    if (byte_offset_q >= MaxBufferBytes) begin
      s_phase   = PhDone;
      s_outcome = StatusTooLong;
      s_start   = MaxBufferBytes;
    end else begin
      unique case (phase_q)
        PhType: begin
          if (entry_count_q >= max_entries_q) begin
            s_phase   = PhDone;
            s_outcome = StatusEndMissing;
            s_start   = byte_offset_q;
          end else if (in_i.data_byte == EndType) begin
            s_phase   = PhDone;
            s_outcome = StatusOk;
            s_start   = byte_offset_q + 16'd1;
          end else begin
            s_type  = in_i.data_byte;
            s_start = byte_offset_q;
            s_phase = PhLenHi;
          end
        end
        PhLenHi: begin
          s_length = {in_i.data_byte, 8'd0};
          s_phase  = PhLenLo;
        end
        PhLenLo: begin
          s_length = length_full;
          if (length_full == 16'd0) begin
            elem_valid = 1'b1;
          end else begin
            s_remaining = length_full;
            s_phase     = PhValue;
          end
        end
        PhValue: begin
          s_remaining = remaining_next;
          if (remaining_next == 16'd0) begin
            elem_valid = 1'b1;
          end
        end
        default: ;
      endcase
      s_offset = byte_offset_q + 16'd1;
    end

    if (elem_valid) begin
      s_phase = PhType;
      if (entry_count_q != EntryCountMax) begin
        s_count = entry_count_q + 8'd1;
      end
    end
    elem_valid = elem_valid && accept;
  end

  always_comb begin
    elem_rec               = '0;
    elem_rec.result_kind   = KindElement;
    elem_rec.element_type  = held_type_q;
    elem_rec.value_length  = s_length;
    elem_rec.value_offset  = element_start_q + HeaderBytes;
    elem_rec.status        = StatusOk;
    elem_rec.last          = !status_valid;

    status_rec             = '0;
    status_rec.result_kind = KindStatus;
    status_rec.last        = 1'b1;
    if (s_phase == PhDone) begin
      status_rec.status        = s_outcome;
      status_rec.parsed_length = s_start;
    end else if (s_phase == PhType) begin
      status_rec.status        = StatusEndMissing;
      status_rec.parsed_length = s_offset;
    end else begin
      status_rec.status        = StatusMalformed;
      status_rec.parsed_length = s_start;
    end
  end

  always_comb begin
    phase_d           = phase_q;
    byte_offset_d     = byte_offset_q;
    element_start_d   = element_start_q;
    held_type_d       = held_type_q;
    held_length_d     = held_length_q;
    value_remaining_d = value_remaining_q;
    entry_count_d     = entry_count_q;
    outcome_d         = outcome_q;
    if (status_valid) begin
      phase_d           = PhType;
      byte_offset_d     = 16'd0;
      element_start_d   = 16'd0;
      held_type_d       = 8'd0;
      held_length_d     = 16'd0;
      value_remaining_d = 16'd0;
      entry_count_d     = 8'd0;
      outcome_d         = StatusOk;
    end else if (accept) begin
      phase_d           = s_phase;
      byte_offset_d     = s_offset;
      element_start_d   = s_start;
      held_type_d       = s_type;
      held_length_d     = s_length;
      value_remaining_d = s_remaining;
      entry_count_d     = s_count;
      outcome_d         = s_outcome;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q           <= PhType;
      byte_offset_q     <= 16'd0;
      element_start_q   <= 16'd0;
      held_type_q       <= 8'd0;
      held_length_q     <= 16'd0;
      value_remaining_q <= 16'd0;
      entry_count_q     <= 8'd0;
      outcome_q         <= StatusOk;
    end else begin
      phase_q           <= phase_d;
      byte_offset_q     <= byte_offset_d;
      element_start_q   <= element_start_d;
      held_type_q       <= held_type_d;
      held_length_q     <= held_length_d;
      value_remaining_q <= value_remaining_d;
      entry_count_q     <= entry_count_d;
      outcome_q         <= outcome_d;
    end
  end

  // Result queue
  assign in_i.ready  = (fifo_cnt_q <= 3'd2);
  assign push_first  = elem_valid || status_valid;
  assign push_second = elem_valid && status_valid;
  assign first_rec   = elem_valid ? elem_rec : status_rec;
  assign push_cnt    = {1'b0, push_second, push_first ^ push_second};
  assign pop         = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i) begin
    if (push_first) begin
      fifo_q[wr_ptr_q] <= first_rec;
    end
    if (push_second) begin
      fifo_q[wr_ptr_q + 2'd1] <= status_rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= 2'd0;
      rd_ptr_q   <= 2'd0;
      fifo_cnt_q <= 3'd0;
    end else begin
      wr_ptr_q   <= wr_ptr_q + push_cnt[1:0];
      rd_ptr_q   <= rd_ptr_q + {1'b0, pop};
      fifo_cnt_q <= fifo_cnt_q + push_cnt - {2'd0, pop};
    end
  end

  assign out_o.valid         = (fifo_cnt_q != 3'd0);
  assign out_o.result_kind   = fifo_q[rd_ptr_q].result_kind;
  assign out_o.element_type  = fifo_q[rd_ptr_q].element_type;
  assign out_o.value_length  = fifo_q[rd_ptr_q].value_length;
  assign out_o.value_offset  = fifo_q[rd_ptr_q].value_offset;
  assign out_o.status        = fifo_q[rd_ptr_q].status;
  assign out_o.parsed_length = fifo_q[rd_ptr_q].parsed_length;
  assign out_o.last          = fifo_q[rd_ptr_q].last;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the TLV stream parser: byte requests from a
// queued driver, records predicted per byte and checked in order at the output.
// Depends on tsp_pkg, tsp_byte_if, tsp_result_if and tlv_stream_parser_unit.
`timescale 1ns / 1ps

module testbench;
  import tsp_pkg::*;

  typedef enum logic [2:0] {
    ExpectType,
    ExpectLenHi,
    ExpectLenLo,
    InValue,
    ParseDone
  } parse_state_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  localparam logic [2:0] MaxEntriesAddr = 3'd0;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        in_valid = 1'b0;
  logic [7:0]  in_data = 8'h00;
  logic        in_last = 1'b0;
  logic        out_ready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  tsp_byte_if   byte_ch ();
  tsp_result_if res_ch ();

  assign byte_ch.valid     = in_valid;
  assign byte_ch.data_byte = in_data;
  assign byte_ch.last_byte = in_last;
  assign res_ch.ready      = out_ready;

  tlv_stream_parser_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (byte_ch),
    .out_o   (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  byte_req_t   pending_bytes[$];
  logic [7:0]  staged_bytes[$];
  result_t     expected_records[$];
  byte_req_t   head;
  result_t     want;
  int          queued_total = 0;
  int          error_count = 0;
  int          burst_left = 8;
  int          gap_left = 0;
  int          hold_left = 0;
  int          recv_count = 0;
  logic [15:0] recv_cycle = 16'd0;

  // Parser mirror and its copy of the entry limit.
  parse_state_e parse_state = ExpectType;
  logic [15:0]  offset_count = 16'd0;
  logic [15:0]  elem_start = 16'd0;
  logic [7:0]   cur_type = 8'd0;
  logic [15:0]  cur_length = 16'd0;
  logic [15:0]  bytes_left = 16'd0;
  logic [7:0]   elem_count = 8'd0;
  logic [1:0]   final_status = StatusOk;
  logic [7:0]   entry_limit = MaxEntriesReset;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #40000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic void predict_byte(input logic [7:0] b, input logic lastb);
    result_t rec;
    logic    complete;
    complete = 1'b0;
    if (offset_count >= MaxBufferBytes) begin
      parse_state  = ParseDone;
      final_status = StatusTooLong;
      elem_start   = MaxBufferBytes;
    end else begin
      case (parse_state)
        ExpectType: begin
          if (elem_count >= entry_limit) begin
            parse_state  = ParseDone;
            final_status = StatusEndMissing;
            elem_start   = offset_count;
          end else if (b == EndType) begin
            parse_state  = ParseDone;
            final_status = StatusOk;
            elem_start   = offset_count + 16'd1;
          end else begin
            cur_type    = b;
            elem_start  = offset_count;
            parse_state = ExpectLenHi;
          end
        end
        ExpectLenHi: begin
          cur_length  = {b, 8'h00};
          parse_state = ExpectLenLo;
        end
        ExpectLenLo: begin
          cur_length[7:0] = b;
          if (cur_length == 16'd0) begin
            complete = 1'b1;
          end else begin
            bytes_left  = cur_length;
            parse_state = InValue;
          end
        end
        InValue: begin
          if (bytes_left != 16'd0) bytes_left--;
          if (bytes_left == 16'd0) complete = 1'b1;
        end
        default: ;
      endcase
      offset_count++;
    end

    if (complete) begin
      rec = '0;
      rec.result_kind  = KindElement;
      rec.element_type = cur_type;
      rec.value_length = cur_length;
      rec.value_offset = elem_start + HeaderBytes;
      rec.last         = !lastb;
      expected_records.push_back(rec);
      if (elem_count != EntryCountMax) elem_count++;
      parse_state = ExpectType;
    end

    if (lastb) begin
      rec = '0;
      rec.result_kind = KindStatus;
      rec.last        = 1'b1;
      case (parse_state)
        ParseDone: begin
          rec.status        = final_status;
          rec.parsed_length = elem_start;
        end
        ExpectType: begin
          rec.status        = StatusEndMissing;
          rec.parsed_length = offset_count;
        end
        default: begin
          rec.status        = StatusMalformed;
          rec.parsed_length = elem_start;
        end
      endcase
      expected_records.push_back(rec);
      parse_state  = ExpectType;
      offset_count = 16'd0;
      elem_start   = 16'd0;
      cur_type     = 8'd0;
      cur_length   = 16'd0;
      bytes_left   = 16'd0;
      elem_count   = 8'd0;
      final_status = StatusOk;
    end
  endfunction

  function automatic void check_field(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      error_count++;
    end
  endfunction

  // Hold the current request until the parser takes it.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && byte_ch.ready) begin
        predict_byte(in_data, in_last);
        head = pending_bytes.pop_front();
      end
      if (!in_valid || byte_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          head = pending_bytes[0];
          in_valid <= 1'b1;
          in_data  <= head.data;
          in_last  <= head.last;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      recv_cycle++;
      if (out_ready && res_ch.valid) recv_count++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (out_ready && res_ch.valid &&
                   (recv_count == 40 || recv_count == 250 || recv_count == 450)) begin
        hold_left = $urandom_range(150, 300);
        out_ready <= 1'b0;
      end else begin
        case (recv_cycle[8:6])
          3'd2:    out_ready <= ($urandom_range(0, 1) == 1);
          3'd3:    out_ready <= ($urandom_range(0, 3) == 0);
          3'd4:    out_ready <= (recv_cycle[2:0] != 3'd0);
          3'd5:    out_ready <= recv_cycle[3];
          3'd6:    out_ready <= ($urandom_range(0, 7) != 0);
          default: out_ready <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && out_ready) begin
      if (expected_records.size() == 0) begin
        $error("result record with none expected, kind %0d", res_ch.result_kind);
        error_count++;
      end else begin
        want = expected_records.pop_front();
        check_field("result_kind", want.result_kind, res_ch.result_kind);
        check_field("element_type", want.element_type, res_ch.element_type);
        check_field("value_length", want.value_length, res_ch.value_length);
        check_field("value_offset", want.value_offset, res_ch.value_offset);
        check_field("status", want.status, res_ch.status);
        check_field("parsed_length", want.parsed_length, res_ch.parsed_length);
        check_field("last", want.last, res_ch.last);
      end
    end
  end

  task automatic stage(input logic [7:0] b);
    staged_bytes.push_back(b);
  endtask

  // Header, then random value bytes; only the first keep bytes are staged.
  task automatic stage_element(input logic [7:0] etype, input logic [15:0] len, input int keep);
    int k;
    for (k = 0; k < keep; k++) begin
      if (k == 0) stage(etype);
      else if (k == 1) stage(len[15:8]);
      else if (k == 2) stage(len[7:0]);
      else stage($urandom_range(0, 255));
    end
  endtask

  task automatic commit_buffer();
    byte_req_t req;
    int        k;
    if (staged_bytes.size() == 0) stage($urandom_range(0, 255));
    for (k = 0; k < staged_bytes.size(); k++) begin
      req.data = staged_bytes[k];
      req.last = (k == staged_bytes.size() - 1);
      pending_bytes.push_back(req);
    end
    queued_total += staged_bytes.size();
    staged_bytes.delete();
  endtask

  task automatic queue_random_buffer();
    int          kind;
    int          n_elem;
    int          e;
    int          len;
    logic [15:0] cut_len;
    kind = $urandom_range(0, 9);
    if (kind == 9) n_elem = $urandom_range(4, 20);
    else if (kind == 8 && entry_limit <= 20) n_elem = entry_limit + $urandom_range(1, 3);
    else n_elem = $urandom_range(0, 4);
    if (kind == 4 && n_elem == 0) n_elem = 1;
    for (e = 0; e < n_elem; e++) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 24) : $urandom_range(0, 4);
      stage_element($urandom_range(1, 255), len, 3 + len);
    end
    case (kind)
      4: ;
      5, 6: begin
        cut_len = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(1, 8);
        if (cut_len == 16'd0) cut_len = 16'd1;
        stage_element($urandom_range(1, 255), cut_len,
                      $urandom_range(1, (cut_len > 16'd6) ? 8 : 2 + cut_len));
      end
      7: begin
        staged_bytes.delete();
        repeat ($urandom_range(1, 8)) stage($urandom_range(0, 255));
      end
      default: begin
        stage(EndType);
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) stage($urandom_range(0, 255));
      end
    endcase
    commit_buffer();
  endtask

  task automatic queue_random(input int target);
    int start;
    start = queued_total;
    while (queued_total - start < target) queue_random_buffer();
  endtask

  // Fills a buffer past the size limit, either ending the list early or
  // running into the limit in the middle of a value.
  task automatic queue_long_buffer(input logic with_end);
    int e;
    for (e = 0; e < (with_end ? 60 : 65); e++) stage_element($urandom_range(1, 255), 16'd1000, 1003);
    if (with_end) stage(EndType);
    else stage_element($urandom_range(1, 255), 16'd2000, 2003);
    while (staged_bytes.size() < 65540) stage($urandom_range(0, 255));
    while (staged_bytes.size() > 65540) staged_bytes.pop_back();
    commit_buffer();
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid || expected_records.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_max_entries(input logic [7:0] value);
    logic [31:0] word;
    word      = $urandom;
    word[7:0] = value;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MaxEntriesAddr;
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    entry_limit = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    stage(EndType);
    commit_buffer();
    stage(8'hFF);
    commit_buffer();
    stage_element(8'hFF, 16'h0000, 3);
    commit_buffer();
    stage_element(8'h01, 16'h0001, 4);
    stage(EndType);
    stage(8'h55);
    commit_buffer();
    stage_element(8'h80, 16'hFFFF, 4);
    commit_buffer();
    stage_element(8'h7F, 16'h0002, 5);
    commit_buffer();
    queue_random(300);
    wait_idle();

    write_max_entries(8'd0);
    stage(8'h01);
    commit_buffer();
    stage(EndType);
    commit_buffer();
    queue_random(100);
    wait_idle();

    write_max_entries(8'd1);
    stage_element(8'h01, 16'h0000, 3);
    stage(8'h02);
    commit_buffer();
    queue_random(250);
    wait_idle();

    write_max_entries(8'd255);
    queue_random(350);
    queue_long_buffer(1'b0);
    queue_long_buffer(1'b1);
    wait_idle();

    write_max_entries(8'd3);
    queue_random(250);
    wait_idle();

    write_max_entries($urandom_range(4, 20));
    queue_random(250);
    wait_idle();
    repeat (16) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/tsp_pkg.sv
rtl/tsp_byte_if.sv
rtl/tsp_result_if.sv
rtl/tlv_stream_parser_unit.sv
tb/testbench.sv
